// ===== rtl/kmr_pkg.sv =====
// Shared types and sizing constants for the keystroke macro recorder.
// No dependencies; imported by every other module of the block.
package kmr_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int MACRO_LEN   = 256;

  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int POS_W       = $clog2(MACRO_LEN + 1);
  localparam int STORE_DEPTH = NUM_SLOTS * MACRO_LEN;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int KEY_W       = 16;
  localparam int SLOT_IN_W   = 8;

  typedef enum logic [1:0] {
    OP_FETCH  = 2'd0,
    OP_RECORD = 2'd1,
    OP_STOP   = 2'd2,
    OP_PLAY   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_NONE          = 4'd0,
    ST_REC_STARTED   = 4'd1,
    ST_REC_COMPLETE  = 4'd2,
    ST_OVR_DECLINED  = 4'd3,
    ST_REC_REF_PLAY  = 4'd4,
    ST_PLAY_REF_REC  = 4'd5,
    ST_PLAY_REF_PLAY = 4'd6,
    ST_ILLEGAL_SLOT  = 4'd7,
    ST_LEN_EXCEEDED  = 4'd8,
    ST_PLAY_STARTED  = 4'd9
  } status_e;

  typedef enum logic {
    CS_IDLE,
    CS_READ
  } ctrl_state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             key_valid;
    logic             used_kbd;
    status_e          status;
    logic             rec;
    logic             play;
  } res_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  wdata;
  } store_req_t;

endpackage

// ===== rtl/kmr_store.sv =====
// Macro key store: single-port synchronous RAM with a registered read.
// Depends on kmr_pkg for depth, address and data widths.
module kmr_store (
  input  logic                 clk_i,
  input  kmr_pkg::store_req_t  req_i,
  output logic [kmr_pkg::KEY_W-1:0] rdata_o
);
  import kmr_pkg::*;

  logic [KEY_W-1:0] mem [STORE_DEPTH];
  logic [KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kmr_ctrl.sv =====
// Command decoder, record/play flags, slot length file and store sequencing.
// Depends on kmr_pkg; drives the kmr_store request and receives its read data.
module kmr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [kmr_pkg::SLOT_IN_W-1:0] slot_i,
  input  logic [kmr_pkg::KEY_W-1:0]     keyboard_key_i,
  input  logic                          confirm_overwrite_i,
  input  logic                          out_free_i,
  output kmr_pkg::store_req_t           store_req_o,
  input  logic [kmr_pkg::KEY_W-1:0]     store_rdata_i,
  output logic                          res_valid_o,
  output kmr_pkg::res_t                 res_o
);
  import kmr_pkg::*;

  localparam int IDX_W = ADDR_W + POS_W;

  ctrl_state_e       state_q, state_d;
  logic              rec_q, rec_d;
  logic              play_q, play_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  cur_len_q, cur_len_d;
  logic [POS_W-1:0]  len_q [NUM_SLOTS];

  logic              len_we;
  logic [SLOT_W-1:0] len_waddr;
  logic [POS_W-1:0]  len_wdata;

  logic              accept;
  logic              issue_read;
  op_e               op;
  logic              slot_legal;
  logic [SLOT_W-1:0] slot_idx;
  logic [POS_W-1:0]  slot_len;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  stop_len;
  logic [IDX_W-1:0]  idx_wide;

  assign op         = op_e'(opcode_i);
  assign slot_legal = {1'b0, slot_i} < (SLOT_IN_W + 1)'(NUM_SLOTS);
  assign slot_idx   = slot_i[SLOT_W-1:0];
  assign slot_len   = slot_legal ? len_q[slot_idx] : '0;
  assign pos_inc    = pos_q + POS_W'(1);
  assign stop_len   = (pos_q != '0) ? pos_q - POS_W'(1) : '0;
  assign idx_wide   = IDX_W'(cur_q) * IDX_W'(MACRO_LEN) + IDX_W'(pos_q);

  assign in_stall_o = !((state_q == CS_IDLE) && out_free_i);
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: if (issue_read) state_d = CS_READ;
      CS_READ: if (out_free_i) state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rec_d      = rec_q;
    play_d     = play_q;
    cur_d      = cur_q;
    pos_d      = pos_q;
    cur_len_d  = cur_len_q;
    len_we     = 1'b0;
    len_waddr  = cur_q;
    len_wdata  = stop_len;
    issue_read = 1'b0;

    store_req_o.we    = 1'b0;
    store_req_o.re    = 1'b0;
    store_req_o.addr  = idx_wide[ADDR_W-1:0];
    store_req_o.wdata = keyboard_key_i;

    res_valid_o     = 1'b0;
    res_o.key       = '0;
    res_o.key_valid = 1'b0;
    res_o.used_kbd  = 1'b0;
    res_o.status    = ST_NONE;

    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_FETCH: begin
              if (play_q) begin
                // key arrives from the store next cycle
                issue_read     = 1'b1;
                store_req_o.re = 1'b1;
                pos_d          = pos_inc;
                if (pos_inc >= cur_len_q) play_d = 1'b0;
              end else begin
                res_o.key       = keyboard_key_i;
                res_o.key_valid = 1'b1;
                res_o.used_kbd  = 1'b1;
                if (rec_q) begin
                  if (pos_q >= POS_W'(MACRO_LEN)) begin
                    res_o.status = ST_LEN_EXCEEDED;
                    rec_d        = 1'b0;
                    len_we       = 1'b1;
                    len_wdata    = POS_W'(MACRO_LEN);
                  end else begin
                    store_req_o.we = 1'b1;
                    pos_d          = pos_inc;
                  end
                end
              end
            end
            OP_RECORD: begin
              if (rec_q) begin
                rec_d        = 1'b0;
                len_we       = 1'b1;
                res_o.status = ST_REC_COMPLETE;
              end else if (play_q) begin
                res_o.status = ST_REC_REF_PLAY;
              end else if (!slot_legal) begin
                res_o.status = ST_ILLEGAL_SLOT;
              end else if ((slot_len != '0) && !confirm_overwrite_i) begin
                res_o.status = ST_OVR_DECLINED;
              end else begin
                rec_d        = 1'b1;
                pos_d        = '0;
                cur_d        = slot_idx;
                len_we       = 1'b1;
                len_waddr    = slot_idx;
                len_wdata    = '0;
                res_o.status = ST_REC_STARTED;
              end
            end
            OP_STOP: begin
              if (rec_q) begin
                rec_d        = 1'b0;
                len_we       = 1'b1;
                res_o.status = ST_REC_COMPLETE;
              end
            end
            OP_PLAY: begin
              if (rec_q) begin
                res_o.status = ST_PLAY_REF_REC;
              end else if (play_q) begin
                res_o.status = ST_PLAY_REF_PLAY;
              end else if (!slot_legal) begin
                res_o.status = ST_ILLEGAL_SLOT;
              end else if (slot_len != '0) begin
                play_d       = 1'b1;
                cur_d        = slot_idx;
                pos_d        = '0;
                cur_len_d    = slot_len;
                res_o.status = ST_PLAY_STARTED;
              end
            end
            default: ;
          endcase
          res_valid_o = !issue_read;
        end
      end
      CS_READ: begin
        res_valid_o     = out_free_i;
        res_o.key       = store_rdata_i;
        res_o.key_valid = 1'b1;
      end
      default: ;
    endcase

    // flags already hold their post-item values during the read cycle
    res_o.rec  = (state_q == CS_READ) ? rec_q  : rec_d;
    res_o.play = (state_q == CS_READ) ? play_q : play_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CS_IDLE;
      rec_q     <= 1'b0;
      play_q    <= 1'b0;
      cur_q     <= '0;
      pos_q     <= '0;
      cur_len_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      rec_q     <= rec_d;
      play_q    <= play_d;
      cur_q     <= cur_d;
      pos_q     <= pos_d;
      cur_len_q <= cur_len_d;
      if (len_we) begin
        len_q[len_waddr] <= len_wdata;
      end
    end
  end

endmodule

// ===== rtl/keystroke_macro_recorder_top.sv =====
// Keystroke macro recorder: records fetched keys into numbered slots and replays
// them. Every transaction yields exactly one result. A fetch during playback
// passes through a read state for the registered read of the macro store RAM;
// every other transaction completes without it. A single output register holds
// the result; while that result is stalled, the input is stalled as well.
// Depends on kmr_pkg, kmr_ctrl and kmr_store.
module keystroke_macro_recorder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [kmr_pkg::SLOT_IN_W-1:0] slot_i,
  input  logic [kmr_pkg::KEY_W-1:0]     keyboard_key_i,
  input  logic                          confirm_overwrite_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kmr_pkg::KEY_W-1:0]     key_out_o,
  output logic                          key_valid_o,
  output logic                          used_keyboard_o,
  output logic [3:0]                    status_o,
  output logic                          is_recording_o,
  output logic                          is_playing_o
);
  import kmr_pkg::*;

  store_req_t       store_req;
  logic [KEY_W-1:0] store_rdata;
  logic             res_valid;
  res_t             res;
  res_t             out_q;
  logic             out_valid_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  kmr_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .slot_i              (slot_i),
    .keyboard_key_i      (keyboard_key_i),
    .confirm_overwrite_i (confirm_overwrite_i),
    .out_free_i          (out_free),
    .store_req_o         (store_req),
    .store_rdata_i       (store_rdata),
    .res_valid_o         (res_valid),
    .res_o               (res)
  );

  kmr_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign key_out_o       = out_q.key;
  assign key_valid_o     = out_q.key_valid;
  assign used_keyboard_o = out_q.used_kbd;
  assign status_o        = out_q.status;
  assign is_recording_o  = out_q.rec;
  assign is_playing_o    = out_q.play;

endmodule

// ===== sim/keystroke_macro_recorder_top_tb.sv =====
// Testbench for keystroke_macro_recorder_top: directed and random keystroke traffic,
// with random idling on both channels, checked against an in-bench macro predictor.
// Depends on kmr_pkg and the RTL of the block.
module keystroke_macro_recorder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmr_pkg::*;

  localparam int N_ITEMS  = 1550;

  typedef struct {
    op_e                  op;
    logic [SLOT_IN_W-1:0] slot;
    logic [KEY_W-1:0]     kbd;
    logic                 confirm;
  } keystroke_t;

  logic                 clk_i               = 1'b0;
  logic                 rst_ni              = 1'b0;
  logic                 in_valid_i          = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           opcode_i            = '0;
  logic [SLOT_IN_W-1:0] slot_i              = '0;
  logic [KEY_W-1:0]     keyboard_key_i      = '0;
  logic                 confirm_overwrite_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i         = 1'b0;
  logic [KEY_W-1:0]     key_out_o;
  logic                 key_valid_o;
  logic                 used_keyboard_o;
  logic [3:0]           status_o;
  logic                 is_recording_o;
  logic                 is_playing_o;

  keystroke_macro_recorder_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .slot_i             (slot_i),
    .keyboard_key_i     (keyboard_key_i),
    .confirm_overwrite_i(confirm_overwrite_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .key_out_o          (key_out_o),
    .key_valid_o        (key_valid_o),
    .used_keyboard_o    (used_keyboard_o),
    .status_o           (status_o),
    .is_recording_o     (is_recording_o),
    .is_playing_o       (is_playing_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state
  logic              mdl_rec  = 1'b0;
  logic              mdl_play = 1'b0;
  logic [SLOT_W-1:0] mdl_slot = '0;
  logic [POS_W-1:0]  mdl_pos  = '0;
  logic [POS_W-1:0]  mdl_len  [NUM_SLOTS];
  logic [KEY_W-1:0]  mdl_keys [STORE_DEPTH];

  keystroke_t keystroke_q[$];
  res_t       pending_results[$];
  keystroke_t offered;
  int         n_accepted = 0;
  int         n_errors   = 0;
  logic       tx_taken   = 1'b0;
  logic       tx_quiet   = 1'b0;
  logic       rx_quiet   = 1'b0;
  logic       hold_rx    = 1'b0;
  int         tx_wait    = 0;
  int         rx_wait    = 0;

  function automatic int store_addr();
    return int'(mdl_slot) * MACRO_LEN + int'(mdl_pos);
  endfunction

  function automatic void close_recording();
    mdl_rec = 1'b0;
    mdl_len[mdl_slot] = (mdl_pos > 0) ? mdl_pos - 1'b1 : '0;
  endfunction

  function automatic res_t next_keystroke_result(keystroke_t k);
    res_t r;
    r = '0;
    case (k.op)
      OP_FETCH: begin
        r.key_valid = 1'b1;
        if (mdl_play) begin
          r.key = mdl_keys[store_addr()];
          mdl_pos++;
          if (mdl_pos >= mdl_len[mdl_slot]) mdl_play = 1'b0;
        end else begin
          r.key = k.kbd;
          r.used_kbd = 1'b1;
        end
        if (mdl_rec) begin
          // slot full: key still goes out, recording closes at full length
          if (mdl_pos >= MACRO_LEN) begin
            r.status = ST_LEN_EXCEEDED;
            mdl_rec = 1'b0;
            mdl_len[mdl_slot] = POS_W'(MACRO_LEN);
          end else begin
            mdl_keys[store_addr()] = r.key;
            mdl_pos++;
          end
        end
      end
      OP_RECORD: begin
        if (mdl_rec) begin
          close_recording();
          r.status = ST_REC_COMPLETE;
        end else if (mdl_play) begin
          r.status = ST_REC_REF_PLAY;
        end else if (k.slot >= NUM_SLOTS) begin
          r.status = ST_ILLEGAL_SLOT;
        end else if (mdl_len[k.slot[SLOT_W-1:0]] != 0 && !k.confirm) begin
          r.status = ST_OVR_DECLINED;
        end else begin
          mdl_rec = 1'b1;
          mdl_pos = '0;
          mdl_slot = k.slot[SLOT_W-1:0];
          mdl_len[mdl_slot] = '0;
          r.status = ST_REC_STARTED;
        end
      end
      OP_STOP: begin
        if (mdl_rec) begin
          close_recording();
          r.status = ST_REC_COMPLETE;
        end
      end
      default: begin
        if (mdl_rec) begin
          r.status = ST_PLAY_REF_REC;
        end else if (mdl_play) begin
          r.status = ST_PLAY_REF_PLAY;
        end else if (k.slot >= NUM_SLOTS) begin
          r.status = ST_ILLEGAL_SLOT;
        end else if (mdl_len[k.slot[SLOT_W-1:0]] != 0) begin
          mdl_play = 1'b1;
          mdl_slot = k.slot[SLOT_W-1:0];
          mdl_pos = '0;
          r.status = ST_PLAY_STARTED;
        end
      end
    endcase
    r.rec = mdl_rec;
    r.play = mdl_play;
    return r;
  endfunction

  function automatic void add(op_e op, int slot, logic [KEY_W-1:0] key, logic conf);
    keystroke_t k;
    k.op = op;
    k.slot = slot[SLOT_IN_W-1:0];
    k.kbd = key;
    k.confirm = conf;
    keystroke_q.push_back(k);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic int rand_slot();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, NUM_SLOTS-1);
  endfunction

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap(logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void fill_random_stream();
    int pick;
    int n;
    int m;
    while (keystroke_q.size() < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // recording session with random keys, occasionally long enough to overflow
        add(OP_RECORD, rand_slot(), rand_key(), $urandom_range(0, 4) != 0);
        n = ($urandom_range(0, 49) == 0) ? $urandom_range(MACRO_LEN-2, MACRO_LEN+4)
                                         : $urandom_range(0, 10);
        repeat (n) begin
          if ($urandom_range(0, 15) == 0)
            add(OP_PLAY, $urandom_range(0, 255), rand_key(), 1'($urandom_range(0, 1)));
          else
            add(OP_FETCH, $urandom_range(0, 255), rand_key(), 1'($urandom_range(0, 1)));
        end
        m = $urandom_range(0, 9);
        if (m < 5)
          add(OP_STOP, $urandom_range(0, 255), rand_key(), 1'($urandom_range(0, 1)));
        else if (m < 9)
          add(OP_RECORD, $urandom_range(0, 255), rand_key(), 1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
        add(OP_PLAY, rand_slot(), rand_key(), 1'($urandom_range(0, 1)));
        n = $urandom_range(0, 12);
        repeat (n) begin
          m = $urandom_range(0, 19);
          if (m == 0)
            add(OP_RECORD, rand_slot(), rand_key(), 1'($urandom_range(0, 1)));
          else if (m == 1)
            add(OP_PLAY, rand_slot(), rand_key(), 1'($urandom_range(0, 1)));
          else
            add(OP_FETCH, $urandom_range(0, 255), rand_key(), 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 4))
          add(op_e'($urandom_range(0, 3)), $urandom_range(0, 255), rand_key(),
              1'($urandom_range(0, 1)));
      end
    end
  endfunction

  // Sender: holds a transaction until it is taken, then idles or offers the next one
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || tx_taken)) begin
      tx_taken = 1'b0;
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid_i <= 1'b0;
      end else if (keystroke_q.size() != 0) begin
        offered = keystroke_q.pop_front();
        opcode_i <= offered.op;
        slot_i <= offered.slot;
        keyboard_key_i <= offered.kbd;
        confirm_overwrite_i <= offered.confirm;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 63) == 0) tx_quiet = ~tx_quiet;
        tx_wait = pick_gap(tx_quiet);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_results.push_back(next_keystroke_result(offered));
      tx_taken = 1'b1;
      n_accepted++;
    end
  end

  // Receiver stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 79) == 0) rx_quiet = ~rx_quiet;
      if (rx_wait == 0) rx_wait = pick_gap(rx_quiet);
      if (rx_wait > 0) rx_wait--;
      out_stall_i <= hold_rx || (rx_wait > 0) || (rx_wait == 0 && 1'b0);
    end
  end

  // Long receiver hold-offs so the block backs up into its input
  initial begin
    int thresholds[2];
    thresholds = '{300, 1000};
    foreach (thresholds[i]) begin
      while (n_accepted < thresholds[i]) @(posedge clk_i);
      hold_rx = 1'b1;
      repeat (80) @(posedge clk_i);
      hold_rx = 1'b0;
    end
  end

  function automatic void flag(string field, int exp_val, int act_val);
    n_errors++;
    $error("%s mismatch: expected %0h, got %0h", field, exp_val, act_val);
  endfunction

  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $error("result transaction with no expectation pending");
      end else begin
        exp_res = pending_results.pop_front();
        if (key_out_o !== exp_res.key) flag("key_out", exp_res.key, key_out_o);
        if (key_valid_o !== exp_res.key_valid)
          flag("key_valid", exp_res.key_valid, key_valid_o);
        if (used_keyboard_o !== exp_res.used_kbd)
          flag("used_keyboard", exp_res.used_kbd, used_keyboard_o);
        if (status_o !== exp_res.status) flag("status", exp_res.status, status_o);
        if (is_recording_o !== exp_res.rec) flag("is_recording", exp_res.rec, is_recording_o);
        if (is_playing_o !== exp_res.play) flag("is_playing", exp_res.play, is_playing_o);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int n_total;
    for (int s = 0; s < NUM_SLOTS; s++) mdl_len[s] = '0;

    // directed: idle fetches, refusals, record/toggle/overwrite, playback conflicts
    add(OP_FETCH, 0, 16'h0000, 1'b0);
    add(OP_FETCH, 255, 16'hFFFF, 1'b1);
    add(OP_STOP, 0, 16'h0000, 1'b0);           // not recording: ignored
    add(OP_PLAY, 0, 16'h0000, 1'b0);           // empty slot
    add(OP_PLAY, 255, 16'h0000, 1'b0);         // illegal slot
    add(OP_RECORD, NUM_SLOTS, 16'h0000, 1'b1); // illegal slot
    add(OP_RECORD, 255, 16'h0000, 1'b1);
    add(OP_RECORD, NUM_SLOTS-1, 16'h0000, 1'b0);
    add(OP_FETCH, 0, 16'hFFFF, 1'b0);
    add(OP_FETCH, 0, 16'h0000, 1'b0);
    add(OP_FETCH, 0, 16'hA5C3, 1'b0);
    add(OP_PLAY, 3, 16'h0000, 1'b0);           // refused while recording
    add(OP_RECORD, 200, 16'h0000, 1'b0);       // toggles off whatever the slot
    add(OP_RECORD, NUM_SLOTS-1, 16'h0000, 1'b0); // overwrite declined
    add(OP_PLAY, NUM_SLOTS-1, 16'h0000, 1'b0);
    add(OP_RECORD, 0, 16'h0000, 1'b1);         // refused while playing
    add(OP_PLAY, NUM_SLOTS-1, 16'h0000, 1'b0); // refused while playing
    add(OP_FETCH, 0, 16'h1111, 1'b0);
    add(OP_FETCH, 0, 16'h2222, 1'b0);
    add(OP_FETCH, 0, 16'h3333, 1'b0);
    add(OP_RECORD, NUM_SLOTS-1, 16'h0000, 1'b1); // overwrite confirmed
    add(OP_STOP, 0, 16'h0000, 1'b0);           // stop at position zero
    add(OP_STOP, 0, 16'h0000, 1'b0);
    add(OP_RECORD, 0, 16'h0000, 1'b0);
    add(OP_FETCH, 0, 16'h1234, 1'b0);
    add(OP_STOP, 0, 16'h0000, 1'b0);

    // fill a slot past its end, then replay it in full
    add(OP_RECORD, NUM_SLOTS-2, rand_key(), 1'b1);
    repeat (MACRO_LEN + 1) add(OP_FETCH, $urandom_range(0, 255), rand_key(), 1'b0);
    add(OP_PLAY, NUM_SLOTS-2, rand_key(), 1'b0);
    repeat (MACRO_LEN + 1) add(OP_FETCH, $urandom_range(0, 255), rand_key(), 1'b1);

    fill_random_stream();
    n_total = keystroke_q.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total) @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (n_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kmr_pkg.sv
rtl/kmr_store.sv
rtl/kmr_ctrl.sv
rtl/keystroke_macro_recorder_top.sv
sim/keystroke_macro_recorder_top_tb.sv
